@@ rtl/sstfc_pkg.sv @@
// ----------------------------------------------------------------------------
// sstfc_pkg
// shared types, codes and elaboration helpers of the sorted symbol table
// ----------------------------------------------------------------------------
package sstfc_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 256;

   // fan-in of each registered level of the match reduction tree
   localparam int TREE_RADIX_LOG = 4;
   localparam int TREE_RADIX     = 1 << TREE_RADIX_LOG;

   localparam int SYM_W   = 8;
   localparam int FREQ_W  = 31;
   localparam int CODE_W  = 8;
   localparam int CLEN_W  = 4;
   localparam int ECNT_W  = 9;

   typedef enum logic [1:0] {
      OP_INSERT    = 2'd0,
      OP_REMOVE    = 2'd1,
      OP_RECOMPUTE = 2'd2,
      OP_LOOKUP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_MISSING = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC
   } state_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_INSERT,
      CMD_REMOVE,
      CMD_RECOMPUTE
   } cmd_kind_type;

   typedef struct packed {
      logic [SYM_W-1:0]  sym;
      logic [FREQ_W-1:0] freq;
      logic [CODE_W-1:0] code;
      logic [CLEN_W-1:0] len;
      logic              valid;
   } entry_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      cmd_kind_type      kind;
      logic [SYM_W-1:0]  sym;
      logic [FREQ_W-1:0] freq;
      logic [CLEN_W-1:0] len;
   } cmd_type;

   // contribution of one cell to the lookup / remove search
   typedef struct packed {
      logic              hit;
      logic              valid;
      logic [CLEN_W-1:0] len;
      logic [CODE_W-1:0] code;
   } match_type;

   // number of nodes on tree level lvl (level 0 is the leaves)
   function automatic int tree_size(int n, int lvl);
      int s;
      s = n;
      for (int i = 0; i < 8; i++) begin
         if (i < lvl) begin
            s = (s + TREE_RADIX - 1) >> TREE_RADIX_LOG;
         end
      end
      return s;
   endfunction

   // number of registered levels needed to reduce n leaves to one node
   function automatic int tree_levels(int n);
      int s;
      int lv;
      s  = n;
      lv = 0;
      for (int i = 0; i < 8; i++) begin
         if (s > 1) begin
            s  = (s + TREE_RADIX - 1) >> TREE_RADIX_LOG;
            lv = lv + 1;
         end
      end
      return lv;
   endfunction

endpackage

@@ rtl/sstfc_cell.sv @@
// ----------------------------------------------------------------------------
// sstfc_cell
// one table slot: holds an entry, compares it with the search key and
// shifts from its left or right neighbor on insert and remove
// ----------------------------------------------------------------------------
module sstfc_cell
   import sstfc_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 9
) (
   input  logic             clock,
   input  cmd_type          cmd,
   input  logic [CNT_W-1:0] count,
   input  entry_type        left_entry,
   input  entry_type        right_entry,
   input  logic             left_gt,
   input  logic             left_match,
   output entry_type        entry_out,
   output logic             gt_out,
   output logic             match_out,
   output match_type        leaf_out
);

   localparam logic [CODE_W-1:0] MY_CODE = CODE_W'(INDEX & ((1 << CODE_W) - 1));

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;
   logic      ge;

   assign occupied = CNT_W'(INDEX) < count;

   // empty slots act as an infinitely large key
   assign gt_out = !occupied || (entry_ff.sym > cmd.sym) ||
                   ((entry_ff.sym == cmd.sym) && (entry_ff.freq > cmd.freq));
   assign ge        = !occupied || (entry_ff.sym >= cmd.sym);
   assign match_out = occupied && (entry_ff.sym == cmd.sym);

   always_comb begin
      leaf_out = '0;
      if (match_out && !left_match) begin
         leaf_out.hit   = 1'b1;
         leaf_out.valid = entry_ff.valid;
         leaf_out.len   = entry_ff.len;
         leaf_out.code  = entry_ff.code;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      case (cmd.kind)
         CMD_INSERT: begin
            if (gt_out && !left_gt) begin
               entry_in.sym   = cmd.sym;
               entry_in.freq  = cmd.freq;
               entry_in.code  = '0;
               entry_in.len   = '0;
               entry_in.valid = 1'b0;
            end else if (gt_out) begin
               entry_in = left_entry;
            end
         end
         CMD_REMOVE: begin
            if (ge) begin
               entry_in = right_entry;
            end
         end
         CMD_RECOMPUTE: begin
            if (occupied) begin
               entry_in.code  = MY_CODE;
               entry_in.len   = cmd.len;
               entry_in.valid = 1'b1;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

@@ rtl/sstfc_or_tree.sv @@
// ----------------------------------------------------------------------------
// sstfc_or_tree
// registered or-reduction of the one-hot match words of all cells
// ----------------------------------------------------------------------------
module sstfc_or_tree
   import sstfc_pkg::*;
#(
   parameter int LEAVES = 256,
   parameter int WIDTH  = 14,
   parameter int LEVELS = 2
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] leaf_i [LEAVES],
   output logic [WIDTH-1:0] result_o
);

   logic [WIDTH-1:0] lvl_ff [LEVELS][LEAVES];

   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      for (genvar j = 0; j < tree_size(LEAVES, l + 1); j++) begin : g_node
         logic [WIDTH-1:0] node_in;
         if (l == 0) begin : g_first
            always_comb begin
               node_in = '0;
               for (int k = 0; k < TREE_RADIX; k++) begin
                  if (j * TREE_RADIX + k < LEAVES) begin
                     node_in = node_in | leaf_i[j * TREE_RADIX + k];
                  end
               end
            end
         end else begin : g_upper
            always_comb begin
               node_in = '0;
               for (int k = 0; k < TREE_RADIX; k++) begin
                  if (j * TREE_RADIX + k < tree_size(LEAVES, l)) begin
                     node_in = node_in | lvl_ff[l-1][j * TREE_RADIX + k];
                  end
               end
            end
         end
         always_ff @(posedge clock) begin
            lvl_ff[l][j] <= node_in;
         end
      end
   end

   assign result_o = lvl_ff[LEVELS-1][0];

endmodule

@@ rtl/sstfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// sstfc_ctrl
// request sequencer: holds the entry count, waits for the match tree,
// issues the cell command and registers the result
// ----------------------------------------------------------------------------
module sstfc_ctrl
   import sstfc_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int CNT_W       = 9,
   parameter int LEVELS      = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  op_type           req_op,
   input  logic [SYM_W-1:0] req_sym,
   input  logic [FREQ_W-1:0] req_freq,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output status_type       rsp_status,
   output logic [CODE_W-1:0] rsp_code,
   output logic [CLEN_W-1:0] rsp_len,
   output logic             rsp_has_code,
   output logic [ECNT_W-1:0] rsp_count,
   output cmd_type          cmd,
   output logic [CNT_W-1:0] count,
   input  match_type        tree_res
);

   localparam int SCAN_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   state_type         state_ff, state_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   op_type            op_ff;
   logic [SYM_W-1:0]  sym_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [CLEN_W-1:0] len_ff, len_in;
   logic              has_ff, has_in;
   logic              accept;
   logic              exec_go;
   cmd_kind_type      kind;
   logic [CLEN_W-1:0] width;
   logic [CNT_W+ECNT_W-1:0] count_wide;

   // ceil(log2(count)), zero for zero or one entry
   function automatic logic [CLEN_W-1:0] code_width(logic [CNT_W-1:0] n);
      logic [CNT_W-1:0]  m;
      logic [CLEN_W-1:0] w;
      m = n - CNT_W'(1);
      w = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (m[i]) begin
            w = CLEN_W'(i + 1);
         end
      end
      if (n <= CNT_W'(1)) begin
         w = '0;
      end
      return w;
   endfunction

   assign accept  = req_tvalid && req_tready;
   assign exec_go = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign width   = code_width(count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_INSERT || req_op == OP_RECOMPUTE) begin
                  state_in = S_EXEC;
               end else begin
                  state_in = S_SCAN;
                  scan_in  = SCAN_W'(LEVELS - 1);
               end
            end
         end
         S_SCAN: begin
            if (scan_ff == '0) begin
               state_in = S_EXEC;
            end else begin
               scan_in = scan_ff - SCAN_W'(1);
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      kind       = CMD_NONE;
      count_in   = count_ff;
      status_in  = status_ff;
      code_in    = code_ff;
      len_in     = len_ff;
      has_in     = has_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_EXEC: begin
            if (exec_go) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_OK;
               code_in      = '0;
               len_in       = '0;
               has_in       = 1'b0;
               case (op_ff)
                  OP_INSERT: begin
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        kind     = CMD_INSERT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (tree_res.hit) begin
                        kind     = CMD_REMOVE;
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        status_in = STATUS_MISSING;
                     end
                  end
                  OP_RECOMPUTE: begin
                     kind = CMD_RECOMPUTE;
                  end
                  OP_LOOKUP: begin
                     if (!tree_res.hit) begin
                        status_in = STATUS_MISSING;
                     end else if (tree_res.valid) begin
                        code_in = tree_res.code;
                        len_in  = tree_res.len;
                        has_in  = 1'b1;
                     end
                  end
                  default: begin
                     kind = CMD_NONE;
                  end
               endcase
            end
         end
         default: begin
            kind = CMD_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         sym_ff  <= req_sym;
         freq_ff <= req_freq;
      end
      status_ff <= status_in;
      code_ff   <= code_in;
      len_ff    <= len_in;
      has_ff    <= has_in;
   end

   assign cmd.kind = kind;
   assign cmd.sym  = sym_ff;
   assign cmd.freq = freq_ff;
   assign cmd.len  = width;
   assign count    = count_ff;

   assign count_wide   = {{ECNT_W{1'b0}}, count_ff};
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_code     = code_ff;
   assign rsp_len      = len_ff;
   assign rsp_has_code = has_ff;
   assign rsp_count    = count_wide[ECNT_W-1:0];

endmodule

@@ rtl/sorted_symbol_table_fixed_codes_core.sv @@
// ----------------------------------------------------------------------------
// sorted_symbol_table_fixed_codes_core
// sorted (symbol, frequency) table in a chain of cells with position codes
// ----------------------------------------------------------------------------
// The table is a row of TABLE_DEPTH cells, each holding one entry, kept in
// ascending order of symbol and then frequency. Every request transfer gives
// exactly one response transfer. Insert and recompute register the request;
// then all cells shift or load in parallel as the response is registered.
// Remove and lookup also wait for the L registered levels of the or-tree
// that collects the first matching cell, with L = ceil(log16(TABLE_DEPTH))
// (L = 2 at the default depth of 256). The cell step waits while a previous
// response is held by rsp_tready. One request is in work at a time; a new
// request is taken while the previous response still waits for rsp_tready.
// Table contents are not cleared by reset, which clears the entry count and
// the sequencer state; a fresh entry has no code until the next recompute,
// and codes stay with their entries when later inserts or removes move them.
// ----------------------------------------------------------------------------
module sorted_symbol_table_fixed_codes_core
   import sstfc_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // symbol [7:0], frequency [38:8], zero [39]
   input  logic [1:0]  req_tuser,   // opcode [1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // code_value [7:0], code_length [11:8],
                                    // has_code [12], entry_count [21:13], zero [23:22]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int LEVELS  = tree_levels(TABLE_DEPTH);
   localparam int MATCH_W = $bits(match_type);

   cmd_type           cmd;
   logic [CNT_W-1:0]  count;
   match_type         tree_res;
   logic [MATCH_W-1:0] tree_vec;

   // per-cell chain signals
   entry_type          entry_w [TABLE_DEPTH];
   logic               gt_w    [TABLE_DEPTH];
   logic               match_w [TABLE_DEPTH];
   logic [MATCH_W-1:0] leaf_w  [TABLE_DEPTH];

   status_type        rsp_status;
   logic [CODE_W-1:0] rsp_code;
   logic [CLEN_W-1:0] rsp_len;
   logic              rsp_has_code;
   logic [ECNT_W-1:0] rsp_count;

   // sequencer and entry count
   sstfc_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CNT_W       (CNT_W),
      .LEVELS      (LEVELS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_op       (op_type'(req_tuser)),
      .req_sym      (req_tdata[7:0]),
      .req_freq     (req_tdata[38:8]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_status   (rsp_status),
      .rsp_code     (rsp_code),
      .rsp_len      (rsp_len),
      .rsp_has_code (rsp_has_code),
      .rsp_count    (rsp_count),
      .cmd          (cmd),
      .count        (count),
      .tree_res     (tree_res)
   );

   // the cell row; insert shifts right from the insert point, remove shifts
   // left from the first matching cell
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_gt;
      logic      left_match;

      if (i == 0) begin : g_head
         assign left_e     = '0;
         assign left_gt    = 1'b0;
         assign left_match = 1'b0;
      end else begin : g_mid
         assign left_e     = entry_w[i-1];
         assign left_gt    = gt_w[i-1];
         assign left_match = match_w[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign right_e = '0;
      end else begin : g_next
         assign right_e = entry_w[i+1];
      end

      sstfc_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count),
         .left_entry  (left_e),
         .right_entry (right_e),
         .left_gt     (left_gt),
         .left_match  (left_match),
         .entry_out   (entry_w[i]),
         .gt_out      (gt_w[i]),
         .match_out   (match_w[i]),
         .leaf_out    (leaf_w[i])
      );
   end

   // collects the single first-match word of the row
   sstfc_or_tree #(
      .LEAVES (TABLE_DEPTH),
      .WIDTH  (MATCH_W),
      .LEVELS (LEVELS)
   ) u_tree (
      .clock    (clock),
      .leaf_i   (leaf_w),
      .result_o (tree_vec)
   );

   assign tree_res = tree_vec;

   assign rsp_tdata = {2'b00, rsp_count, rsp_has_code, rsp_len, rsp_code};
   assign rsp_tuser = rsp_status;

endmodule

@@ rtl/sstfc_checker.sv @@
// ----------------------------------------------------------------------------
// sstfc_checker
// port-level checks of the sorted symbol table, bound to the top level
// ----------------------------------------------------------------------------
module sstfc_checker
   import sstfc_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   localparam logic [ECNT_W-1:0] FULL_COUNT = ECNT_W'(TABLE_DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_code_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |-> rsp_tuser == STATUS_OK)
      else $error("code reported with a fault status");

   a_no_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[12] |-> rsp_tdata[11:0] == 12'd0)
      else $error("code bits set without a code");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_FULL |-> rsp_tdata[21:13] == FULL_COUNT)
      else $error("table full reported below depth");

endmodule

bind sorted_symbol_table_fixed_codes_core sstfc_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_sstfc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
